[rtl/fms_pkg.sv]
// shared constants, types and codes for the multi-stack block
package fms_pkg;

	localparam int NUM_STACKS  = 3;
	localparam int STACK_DEPTH = 16;

	localparam int DATA_W = 32;
	localparam int OP_W   = 2;
	localparam int ID_W   = 2;
	localparam int CAP_W  = 5;
	localparam int ST_W   = 2;
	localparam int FILL_W = $clog2(STACK_DEPTH + 1);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// shift commands for one stack lane
	typedef struct packed {
		logic push;
		logic pop;
	} lane_ctl_t;

	// what a lane shows to the decoder
	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic [DATA_W-1:0] top;
	} lane_stat_t;

endpackage

[rtl/fms_if.sv]
// request, response and configuration channel interfaces

interface fms_req_if
	import fms_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ID_W-1:0]   stack_id;
	logic [DATA_W-1:0] push_value;

	modport source (output valid, op, stack_id, push_value, input ready);
	modport sink   (input valid, op, stack_id, push_value, output ready);
endinterface

interface fms_rsp_if
	import fms_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_value;
	logic [ST_W-1:0]   status;

	modport source (output valid, read_value, status, input ready);
	modport sink   (input valid, read_value, status, output ready);
endinterface

interface fms_cfg_if
	import fms_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[rtl/fixed_multi_stack.sv]
// several fixed-size stacks, each a row of shift cells, with one result per request
// a result is registered and shown in the cycle after its request is accepted
// one request per cycle unless stalled; each op touches at most one lane and its fill count
// the response register frees a slot when its result is taken in the same cycle
// reset: fill counts clear to zero and capacity returns to sixteen; cell words are not reset
module fixed_multi_stack
	import fms_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	fms_req_if.sink   req,
	fms_rsp_if.source rsp,
	fms_cfg_if.sink   cfg
);

	logic [CAP_W-1:0]  cap_q;
	logic              rsp_valid_q;
	logic [DATA_W-1:0] rsp_value_q;
	status_t           rsp_status_q;

	lane_ctl_t         lane_ctl  [NUM_STACKS];
	lane_stat_t        lane_stat [NUM_STACKS];
	logic [NUM_STACKS-1:0] lane_act;

	logic              fire;
	op_t               op;
	logic              sid_ok;
	lane_stat_t        sel;
	logic              is_full;
	logic              is_empty;
	logic [DATA_W-1:0] res_value;
	status_t           res_status;

	// capacity register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.data;
		end
	end

	// request handshake
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign op        = op_t'(req.op);
	assign sid_ok    = int'(req.stack_id) < NUM_STACKS;

	// select the addressed lane
	always_comb begin
		sel = '0;
		for (int s = 0; s < NUM_STACKS; s++) begin
			if (int'(req.stack_id) == s) begin
				sel = lane_stat[s];
			end
		end
	end

	assign is_full  = !sid_ok || int'(sel.fill) >= int'(cap_q)
		|| int'(sel.fill) >= STACK_DEPTH;
	assign is_empty = !sid_ok || sel.fill == '0;

	// result decode
	always_comb begin
		res_value  = '0;
		res_status = ST_DONE;
		unique case (op)
			OP_PUSH: begin
				if (is_full) begin
					res_status = ST_FULL;
				end
			end
			OP_POP, OP_PEEK: begin
				if (is_empty) begin
					res_value  = '1;
					res_status = ST_EMPTY;
				end else begin
					res_value = sel.top;
				end
			end
			OP_NONE: begin
				res_value  = '0;
				res_status = ST_DONE;
			end
			default: begin
				res_value  = '0;
				res_status = ST_DONE;
			end
		endcase
	end

	// shift commands to the lanes
	for (genvar s = 0; s < NUM_STACKS; s++) begin : g_lane
		logic hit;

		assign hit = fire && int'(req.stack_id) == s;
		assign lane_ctl[s].push = hit && op == OP_PUSH && !is_full;
		assign lane_ctl[s].pop  = hit && op == OP_POP && !is_empty;
		assign lane_act[s]      = lane_ctl[s].push || lane_ctl[s].pop;

		fms_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (lane_ctl[s]),
			.push_value (req.push_value),
			.stat       (lane_stat[s])
		);
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_value_q  <= res_value;
			rsp_status_q <= res_status;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.status     = rsp_status_q;

	// every accepted request shows a result in the next cycle
	a_fire_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("accepted request produced no response");

	// at most one lane shifts in a cycle
	a_one_lane: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lane_act))
		else $error("more than one lane shifted");

	// empty responses always carry the all-ones value
	a_empty_val: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q == ST_EMPTY |-> rsp_value_q == '1)
		else $error("empty response with wrong value");

	// a lane never shifts without an accepted request
	a_act_fire: assert property (@(posedge clk) disable iff (!arst_n)
		lane_act != '0 |-> fire)
		else $error("lane shifted without a request");

endmodule

[rtl/fms_cell.sv]
// one storage cell of a stack lane, shifting with its neighbors
module fms_cell
	import fms_pkg::*;
(
	input  logic              clk,
	input  lane_ctl_t         ctl,
	input  logic [DATA_W-1:0] above,
	input  logic [DATA_W-1:0] below,
	output logic [DATA_W-1:0] word
);

	logic [DATA_W-1:0] word_q;

	// push moves words down the lane, pop moves them up
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			word_q <= above;
		end else if (ctl.pop) begin
			word_q <= below;
		end
	end

	assign word = word_q;

endmodule

[rtl/fms_lane.sv]
// one stack: a chain of shift cells with the top at cell zero, plus fill count
module fms_lane
	import fms_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  lane_ctl_t         ctl,
	input  logic [DATA_W-1:0] push_value,
	output lane_stat_t        stat
);

	logic [DATA_W-1:0] chain [STACK_DEPTH];
	logic [FILL_W-1:0] fill_q;

	// fill count tracks the number of live cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.push) begin
			fill_q <= fill_q + FILL_W'(1);
		end else if (ctl.pop) begin
			fill_q <= fill_q - FILL_W'(1);
		end
	end

	// cell row, each fed by its upper and lower neighbor
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] above;
		logic [DATA_W-1:0] below;

		if (i == 0) begin : g_top
			assign above = push_value;
		end else begin : g_mid
			assign above = chain[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_bot
			assign below = '0;
		end else begin : g_up
			assign below = chain[i+1];
		end

		fms_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.above (above),
			.below (below),
			.word  (chain[i])
		);
	end

	assign stat.fill = fill_q;
	assign stat.top  = chain[0];

endmodule

[bench/tb_top.sv]
// self-checking bench for the fixed-size multi-stack block: directed table then random phases
`timescale 1ns / 1ps

module tb_top;
	import fms_pkg::*;

	localparam int        CYCLE_LIMIT  = 500000;
	localparam int        RANDOM_ITEMS = 1850;
	localparam logic [DATA_W-1:0] EMPTY_READ = '1;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		status_t           status;
	} stack_result_t;

	typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   sid;
		logic [DATA_W-1:0] value;
		logic              typed;
		stack_result_t     result;
	} plan_row_t;

	logic clk;
	logic arst_n;

	fms_req_if req_ch();
	fms_rsp_if rsp_ch();
	fms_cfg_if cfg_ch();

	fixed_multi_stack u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// shadow copy of the stacks and the capacity register
	logic [DATA_W-1:0] stack_words [NUM_STACKS][STACK_DEPTH];
	int unsigned       stack_count [NUM_STACKS];
	logic [CAP_W-1:0]  capacity;

	stack_result_t expected_q [$];
	bit            row_typed;
	stack_result_t row_result;
	bit            quiet;
	int            fail_count;
	int            cycle_count;
	int            status_seen [4];
	int            cap_writes;
	int            request_count;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// next state of the shadow stacks and the result one request gives
	function automatic stack_result_t predict_op(logic [OP_W-1:0] op, logic [ID_W-1:0] sid,
			logic [DATA_W-1:0] value);
		stack_result_t res;
		int unsigned   lim;
		int unsigned   top;
		res.read_value = '0;
		res.status     = ST_DONE;
		lim = (capacity > STACK_DEPTH) ? STACK_DEPTH : capacity;
		case (op)
			OP_PUSH: begin
				if (sid >= NUM_STACKS || stack_count[sid] >= lim) begin
					res.status = ST_FULL;
				end else begin
					stack_words[sid][stack_count[sid]] = value;
					stack_count[sid]++;
				end
			end
			OP_POP, OP_PEEK: begin
				if (sid >= NUM_STACKS || stack_count[sid] == 0) begin
					res.read_value = EMPTY_READ;
					res.status     = ST_EMPTY;
				end else begin
					top = stack_count[sid] - 1;
					res.read_value = stack_words[sid][top];
					if (op == OP_POP)
						stack_count[sid] = top;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// gap length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic logic [CAP_W-1:0] pick_capacity();
		case ($urandom_range(7))
			0: return CAP_W'(0);
			1: return CAP_W'(1);
			2: return CAP_W'(STACK_DEPTH);
			3: return '1;
			4: return CAP_W'(STACK_DEPTH + 1);
			default: return CAP_W'($urandom_range(31));
		endcase
	endfunction

	// op mix by phase: 0 mostly push, 1 mostly pop, 2 balanced
	function automatic logic [OP_W-1:0] pick_op(int mode);
		int r;
		int push_lim;
		int pop_lim;
		r = $urandom_range(99);
		case (mode)
			0:       begin push_lim = 70; pop_lim = 88; end
			1:       begin push_lim = 30; pop_lim = 85; end
			default: begin push_lim = 50; pop_lim = 80; end
		endcase
		if (r < 4)
			return OP_NONE;
		else if (r < push_lim)
			return OP_PUSH;
		else if (r < pop_lim)
			return OP_POP;
		else
			return OP_PEEK;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(19))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic plan_row_t op_row(logic [OP_W-1:0] op, logic [ID_W-1:0] sid,
			logic [DATA_W-1:0] value, logic typed = 1'b0,
			logic [DATA_W-1:0] rd = '0, status_t st = ST_DONE);
		plan_row_t row;
		row.kind              = ROW_REQ;
		row.op                = op;
		row.sid               = sid;
		row.value             = value;
		row.typed             = typed;
		row.result.read_value = rd;
		row.result.status     = st;
		return row;
	endfunction

	function automatic plan_row_t cap_row(logic [CAP_W-1:0] cap);
		plan_row_t row;
		row       = op_row(OP_NONE, '0, DATA_W'(cap));
		row.kind  = ROW_CAP;
		return row;
	endfunction

	// present one request after a random gap and hold it until taken
	task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] sid,
			logic [DATA_W-1:0] value, logic typed, stack_result_t result);
		int gap;
		gap = quiet ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= op;
		req_ch.stack_id   <= sid;
		req_ch.push_value <= value;
		row_typed  = typed;
		row_result = result;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// stop requesting and wait until every result is back
	task automatic settle(int pause);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (pause) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		settle(3);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= cap;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// response side stalls
	initial begin
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(99) < 20) begin
				rsp_ch.ready <= 1'b0;
				repeat (idle_len() + 1) @(negedge clk);
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// monitor: predict on request, check on result, track capacity writes
	always @(posedge clk) begin
		stack_result_t predicted;
		stack_result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_q.size());
			$display("RESULT: ERROR");
			$finish;
		end else if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				predicted = predict_op(req_ch.op, req_ch.stack_id, req_ch.push_value);
				expected_q.push_back(row_typed ? row_result : predicted);
				request_count++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				status_seen[rsp_ch.status]++;
				if (expected_q.size() == 0) begin
					$error("unexpected result: read_value %h status %0d",
						rsp_ch.read_value, rsp_ch.status);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (rsp_ch.read_value !== want.read_value) begin
						$error("read_value: expected %h, actual %h",
							want.read_value, rsp_ch.read_value);
						fail_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, actual %0d",
							want.status, rsp_ch.status);
						fail_count++;
					end
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				capacity = cfg_ch.data;
				cap_writes++;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		plan_row_t         plan [$];
		int                n_items;
		int                mode;
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   sid;

		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.op         = '0;
		req_ch.stack_id   = '0;
		req_ch.push_value = '0;
		rsp_ch.ready      = 1'b1;
		cfg_ch.valid      = 1'b0;
		cfg_ch.data       = '0;
		capacity          = CAP_RESET;
		quiet             = 1'b0;
		row_typed         = 1'b0;
		row_result        = '0;
		foreach (stack_count[i])
			stack_count[i] = 0;

		// empty stacks, absent stack, unused op
		plan.push_back(op_row(OP_PEEK, 2'd0, '0, 1'b1, EMPTY_READ, ST_EMPTY));
		plan.push_back(op_row(OP_POP, 2'd2, '1, 1'b1, EMPTY_READ, ST_EMPTY));
		plan.push_back(op_row(OP_PUSH, 2'd3, '1, 1'b1, '0, ST_FULL));
		plan.push_back(op_row(OP_POP, 2'd3, '0, 1'b1, EMPTY_READ, ST_EMPTY));
		plan.push_back(op_row(OP_PEEK, 2'd3, '0, 1'b1, EMPTY_READ, ST_EMPTY));
		plan.push_back(op_row(OP_NONE, 2'd1, 32'hAAAA_5555, 1'b1, '0, ST_DONE));
		// extreme values through the stacks
		plan.push_back(op_row(OP_PUSH, 2'd0, 32'h7FFF_FFFF, 1'b1, '0, ST_DONE));
		plan.push_back(op_row(OP_PUSH, 2'd0, 32'h8000_0000, 1'b1, '0, ST_DONE));
		plan.push_back(op_row(OP_PEEK, 2'd0, '0, 1'b1, 32'h8000_0000, ST_DONE));
		plan.push_back(op_row(OP_POP, 2'd0, '0, 1'b1, 32'h8000_0000, ST_DONE));
		plan.push_back(op_row(OP_POP, 2'd0, '0, 1'b1, 32'h7FFF_FFFF, ST_DONE));
		plan.push_back(op_row(OP_PUSH, 2'd1, '0, 1'b1, '0, ST_DONE));
		plan.push_back(op_row(OP_PUSH, 2'd2, '1, 1'b1, '0, ST_DONE));
		plan.push_back(op_row(OP_PUSH, 2'd2, $urandom));
		plan.push_back(op_row(OP_POP, 2'd2, '0));
		plan.push_back(op_row(OP_PEEK, 2'd2, '0, 1'b1, '1, ST_DONE));
		plan.push_back(op_row(OP_NONE, 2'd3, '1, 1'b1, '0, ST_DONE));
		// zero capacity refuses every push
		plan.push_back(cap_row(CAP_W'(0)));
		plan.push_back(op_row(OP_PUSH, 2'd0, 32'h1234_5678, 1'b1, '0, ST_FULL));
		plan.push_back(op_row(OP_POP, 2'd1, '0, 1'b1, '0, ST_DONE));
		plan.push_back(op_row(OP_POP, 2'd1, '0, 1'b1, EMPTY_READ, ST_EMPTY));
		// capacity equal to the current fill of stack two
		plan.push_back(cap_row(CAP_W'(1)));
		plan.push_back(op_row(OP_PUSH, 2'd2, 32'h5A5A_5A5A, 1'b1, '0, ST_FULL));
		plan.push_back(op_row(OP_PUSH, 2'd1, $urandom));
		plan.push_back(op_row(OP_PUSH, 2'd1, '0, 1'b1, '0, ST_FULL));
		// capacity above the depth
		plan.push_back(cap_row('1));
		plan.push_back(op_row(OP_PEEK, 2'd2, '0, 1'b1, '1, ST_DONE));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CAP)
				write_capacity(plan[i].value[CAP_W-1:0]);
			else
				send_request(plan[i].op, plan[i].sid, plan[i].value, plan[i].typed,
					plan[i].result);
		end

		// random phases, each under a fresh capacity with its own op mix
		n_items = 0;
		while (n_items < RANDOM_ITEMS) begin
			write_capacity(pick_capacity());
			quiet = ($urandom_range(7) == 0);
			mode  = $urandom_range(2);
			repeat ($urandom_range(20, 80)) begin
				op  = pick_op(mode);
				sid = ($urandom_range(99) < 6) ? ID_W'(3) : ID_W'($urandom_range(NUM_STACKS - 1));
				send_request(op, sid, pick_value(), 1'b0, '0);
				if (op != OP_NONE)
					n_items++;
			end
			quiet = 1'b0;
		end

		settle(8);
		$display("covered %0d requests over %0d capacity writes in %0d cycles",
			request_count, cap_writes, cycle_count);
		$display("results seen: %0d done, %0d full, %0d empty; %0d mismatches",
			status_seen[ST_DONE], status_seen[ST_FULL], status_seen[ST_EMPTY], fail_count);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
rtl/fms_pkg.sv
rtl/fms_if.sv
rtl/fms_cell.sv
rtl/fms_lane.sv
rtl/fixed_multi_stack.sv
bench/tb_top.sv
